### sv/rfp_pkg.sv
package rfp_pkg;

  // parser phase
  typedef enum logic [3:0] {
    PH_KEYLEN = 4'd0,
    PH_KEY    = 4'd1,
    PH_COUNT  = 4'd2,
    PH_TYPE   = 4'd3,
    PH_VLEN   = 4'd4,
    PH_STR    = 4'd5,
    PH_INT    = 4'd6,
    PH_SKIP   = 4'd7,
    PH_IDLE   = 4'd8
  } phase_t;

  // byte roles
  localparam logic [3:0] ROLE_IGNORED = 4'd0;
  localparam logic [3:0] ROLE_KEYLEN  = 4'd1;
  localparam logic [3:0] ROLE_KEY     = 4'd2;
  localparam logic [3:0] ROLE_COUNT   = 4'd3;
  localparam logic [3:0] ROLE_TYPE    = 4'd4;
  localparam logic [3:0] ROLE_VLEN    = 4'd5;
  localparam logic [3:0] ROLE_STRING  = 4'd6;
  localparam logic [3:0] ROLE_INT     = 4'd7;
  localparam logic [3:0] ROLE_SKIPPED = 4'd8;

  // error codes
  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_SHORT        = 3'd1;
  localparam logic [2:0] ERR_KEY_OVERRUN  = 3'd2;
  localparam logic [2:0] ERR_STR_OVERRUN  = 3'd3;
  localparam logic [2:0] ERR_INT_OVERRUN  = 3'd4;
  localparam logic [2:0] ERR_BAD_INT_LEN  = 3'd5;
  localparam logic [2:0] ERR_BAD_TYPE     = 3'd6;

  // field type codes and the fixed int32 length
  localparam logic [31:0] TYPE_STRING = 32'd1;
  localparam logic [31:0] TYPE_INT32  = 32'd2;
  localparam logic [31:0] INT32_LEN   = 32'd4;

  typedef struct packed {
    phase_t      phase;
    logic [1:0]  word_byte_count;
    logic [31:0] length_shift;
    logic [31:0] bytes_remaining;
    logic [31:0] fields_total;
    logic [31:0] field_counter;
    logic [31:0] type_held;
    logic [31:0] int_accumulator;
  } parse_state_t;

  typedef struct packed {
    logic [3:0]         byte_role;
    logic [7:0]         data_echo;
    logic [31:0]        field_number;
    logic               field_complete;
    logic               field_is_integer;
    logic signed [31:0] integer_value;
    logic               record_complete;
    logic [2:0]         error_code;
  } parse_result_t;

  localparam parse_state_t STATE_RESET = '{
    phase:           PH_KEYLEN,
    word_byte_count: 2'd0,
    length_shift:    32'd0,
    bytes_remaining: 32'd0,
    fields_total:    32'd0,
    field_counter:   32'd0,
    type_held:       32'd0,
    int_accumulator: 32'd0
  };

endpackage

### sv/rfp_step.sv
module rfp_step (
  input  rfp_pkg::parse_state_t  cur,
  input  logic [7:0]             data_byte,
  input  logic                   end_of_buffer,
  output rfp_pkg::parse_state_t  nxt,
  output rfp_pkg::parse_result_t res
);
  import rfp_pkg::*;

  logic [31:0] shift_new;
  logic [1:0]  wbc_new;
  logic        word_done;
  logic [31:0] remaining_dec;
  logic [31:0] counter_inc;
  logic [31:0] acc_new;
  logic        last_field;

  // shared datapath pieces
  assign shift_new     = {cur.length_shift[23:0], data_byte};
  assign wbc_new       = cur.word_byte_count + 2'd1;
  assign word_done     = (cur.word_byte_count == 2'd3);
  assign remaining_dec = cur.bytes_remaining - 32'd1;
  assign counter_inc   = cur.field_counter + 32'd1;
  assign acc_new       = {cur.int_accumulator[23:0], data_byte};
  assign last_field    = (counter_inc == cur.fields_total);

  always_comb begin
    nxt = cur;
    res = '0;
    res.data_echo = data_byte;

    case (cur.phase)
      PH_KEYLEN: begin
        res.byte_role = ROLE_KEYLEN;
        nxt.length_shift    = shift_new;
        nxt.word_byte_count = wbc_new;
        if (word_done) begin
          if (shift_new == 32'd0) begin
            nxt.phase = PH_COUNT;
            if (end_of_buffer) res.error_code = ERR_SHORT;
          end else begin
            nxt.bytes_remaining = shift_new;
            nxt.phase = PH_KEY;
            if (end_of_buffer) res.error_code = ERR_KEY_OVERRUN;
          end
        end else if (end_of_buffer) begin
          res.error_code = ERR_SHORT;
        end
      end
      PH_KEY: begin
        res.byte_role = ROLE_KEY;
        nxt.bytes_remaining = remaining_dec;
        if (remaining_dec == 32'd0) begin
          nxt.phase = PH_COUNT;
          if (end_of_buffer) res.error_code = ERR_SHORT;
        end else if (end_of_buffer) begin
          res.error_code = ERR_KEY_OVERRUN;
        end
      end
      PH_COUNT: begin
        res.byte_role = ROLE_COUNT;
        nxt.length_shift    = shift_new;
        nxt.word_byte_count = wbc_new;
        if (word_done) begin
          nxt.fields_total  = shift_new;
          nxt.field_counter = 32'd0;
          if (shift_new == 32'd0) begin
            res.record_complete = 1'b1;
            nxt.phase = PH_IDLE;
          end else begin
            nxt.phase = PH_TYPE;
            if (end_of_buffer) res.error_code = ERR_SHORT;
          end
        end else if (end_of_buffer) begin
          res.error_code = ERR_SHORT;
        end
      end
      PH_TYPE: begin
        res.byte_role    = ROLE_TYPE;
        res.field_number = cur.field_counter;
        nxt.length_shift    = shift_new;
        nxt.word_byte_count = wbc_new;
        if (word_done) begin
          nxt.type_held = shift_new;
          nxt.phase = PH_VLEN;
        end
        if (end_of_buffer) res.error_code = ERR_SHORT;
      end
      PH_VLEN: begin
        res.byte_role    = ROLE_VLEN;
        res.field_number = cur.field_counter;
        nxt.length_shift    = shift_new;
        nxt.word_byte_count = wbc_new;
        if (!word_done) begin
          if (end_of_buffer) res.error_code = ERR_SHORT;
        end else if (cur.type_held == TYPE_STRING) begin
          if (shift_new == 32'd0) begin
            // empty string completes on its length word
            res.field_complete = 1'b1;
            nxt.field_counter  = counter_inc;
            if (last_field) begin
              res.record_complete = 1'b1;
              nxt.phase = PH_IDLE;
            end else begin
              nxt.phase = PH_TYPE;
              if (end_of_buffer) res.error_code = ERR_SHORT;
            end
          end else begin
            nxt.bytes_remaining = shift_new;
            nxt.phase = PH_STR;
            if (end_of_buffer) res.error_code = ERR_STR_OVERRUN;
          end
        end else if (cur.type_held == TYPE_INT32) begin
          if (shift_new == INT32_LEN) begin
            nxt.bytes_remaining = INT32_LEN;
            nxt.int_accumulator = 32'd0;
            nxt.phase = PH_INT;
            if (end_of_buffer) res.error_code = ERR_INT_OVERRUN;
          end else if (shift_new == 32'd0) begin
            res.error_code = ERR_BAD_INT_LEN;
          end else begin
            nxt.bytes_remaining = shift_new;
            nxt.phase = PH_SKIP;
            if (end_of_buffer) res.error_code = ERR_INT_OVERRUN;
          end
        end else begin
          res.error_code = ERR_BAD_TYPE;
        end
      end
      PH_STR: begin
        res.byte_role    = ROLE_STRING;
        res.field_number = cur.field_counter;
        nxt.bytes_remaining = remaining_dec;
        if (remaining_dec == 32'd0) begin
          res.field_complete = 1'b1;
          nxt.field_counter  = counter_inc;
          if (last_field) begin
            res.record_complete = 1'b1;
            nxt.phase = PH_IDLE;
          end else begin
            nxt.phase = PH_TYPE;
            if (end_of_buffer) res.error_code = ERR_SHORT;
          end
        end else if (end_of_buffer) begin
          res.error_code = ERR_STR_OVERRUN;
        end
      end
      PH_INT: begin
        res.byte_role    = ROLE_INT;
        res.field_number = cur.field_counter;
        nxt.int_accumulator = acc_new;
        nxt.bytes_remaining = remaining_dec;
        if (remaining_dec == 32'd0) begin
          res.field_complete   = 1'b1;
          res.field_is_integer = 1'b1;
          res.integer_value    = acc_new;
          nxt.field_counter    = counter_inc;
          if (last_field) begin
            res.record_complete = 1'b1;
            nxt.phase = PH_IDLE;
          end else begin
            nxt.phase = PH_TYPE;
            if (end_of_buffer) res.error_code = ERR_SHORT;
          end
        end else if (end_of_buffer) begin
          res.error_code = ERR_INT_OVERRUN;
        end
      end
      PH_SKIP: begin
        res.byte_role    = ROLE_SKIPPED;
        res.field_number = cur.field_counter;
        nxt.bytes_remaining = remaining_dec;
        if (remaining_dec == 32'd0) begin
          res.error_code = ERR_BAD_INT_LEN;
        end else if (end_of_buffer) begin
          res.error_code = ERR_INT_OVERRUN;
        end
      end
      default: begin
        res.byte_role = ROLE_IGNORED;
      end
    endcase

    // an error parks the parser until the end of the buffer
    if (res.error_code != ERR_NONE) nxt.phase = PH_IDLE;
    // end of buffer restarts everything for the next buffer
    if (end_of_buffer) nxt = STATE_RESET;
  end

endmodule

### sv/record_frame_parser.sv
// record_frame_parser: byte-serial parser for length-prefixed key/field records.
// Input stream: one buffer byte per request on s_tdata, s_tlast on the final
// byte of the buffer. Output stream: one tagged result per input byte. The
// role of the byte goes on m_tuser, m_tlast marks the byte that finishes the
// record, and m_tdata carries the echoed byte, field index, completion flags,
// decoded int32 and error code.
// A byte accepted on the input goes through the input register, then the parse
// logic into the result register. Throughput: one byte per cycle when the
// output is not stalled; the parse state update is a single pass of 32-bit
// add/compare logic between the input register and the state registers.
// The input register holds one byte while the result register is stalled, so
// s_tready drops only when both are full; a stalled result holds its payload.
// Reset (rst, synchronous) empties both registers and returns the parser to
// waiting for a key length. The parser also returns to that state after every
// byte that has s_tlast set, so each buffer is parsed independently.
module record_frame_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // end_of_buffer
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // [7:0] data_echo, [39:8] field_number,
                                 // [40] field_complete, [41] field_is_integer,
                                 // [73:42] integer_value, [76:74] error_code,
                                 // [79:77] zero
  output logic [3:0]  m_tuser,   // [3:0] byte_role
  output logic        m_tlast    // record_complete
);
  import rfp_pkg::*;

  logic          in_valid;
  logic [7:0]    in_byte;
  logic          in_last;
  parse_state_t  state;
  parse_state_t  state_next;
  parse_result_t step_res;
  parse_result_t result;
  logic          fire;

  // move a byte from the input register to the result register
  assign fire     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  rfp_step u_step (
    .cur           (state),
    .data_byte     (in_byte),
    .end_of_buffer (in_last),
    .nxt           (state_next),
    .res           (step_res)
  );

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (fire) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (fire) begin
      result <= step_res;
    end
  end

  assign m_tdata = {3'b000, result.error_code, result.integer_value,
                    result.field_is_integer, result.field_complete,
                    result.field_number, result.data_echo};
  assign m_tuser = result.byte_role;
  assign m_tlast = result.record_complete;

endmodule
